[hw/rtl/svpd_pkg.sv]
// ----------------------------------------------------------------------------
// svpd_pkg
// Shared constants, stage types and sector codes for the space vector PWM
// duty pipeline.
// ----------------------------------------------------------------------------
package svpd_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int VOLT_WIDTH = 16;
  localparam int PER_W      = 16;

  // normalized Q2.F values and the division that makes them
  localparam int NW   = FRAC_BITS + 2;
  localparam int REMW = VOLT_WIDTH + 1;
  // 1/sqrt3 and 2/sqrt3 in Q1.F, signed operand width
  localparam int KW   = FRAC_BITS + 2;
  localparam int PW   = NW + KW;
  // term, product, time, center and duty widths
  localparam int XW   = NW + 2;
  localparam int PRW  = XW + PER_W + 1;
  localparam int TW   = PRW - FRAC_BITS;
  localparam int CW   = TW + 1;
  localparam int DW   = CW + 1;

  localparam longint InvSqrt3Q24    = 64'd9686330;
  localparam longint TwoInvSqrt3Q24 = 64'd19372660;
  localparam int     QShift         = 24 - FRAC_BITS;
  localparam longint QHalf          = (64'd1 << QShift) >> 1;
  localparam logic [KW-1:0] K1 = KW'((InvSqrt3Q24 + QHalf) >> QShift);
  localparam logic [KW-1:0] K2 = KW'((TwoInvSqrt3Q24 + QHalf) >> QShift);

  localparam logic [NW-1:0] QLIM = NW'(64'd1 << (FRAC_BITS + 1));

  localparam logic [PER_W-1:0] PERIOD_RST = PER_W'(1000);

  typedef enum logic [2:0] {
    SECT_1 = 3'd1,
    SECT_2 = 3'd2,
    SECT_3 = 3'd3,
    SECT_4 = 3'd4,
    SECT_5 = 3'd5,
    SECT_6 = 3'd6
  } sector_e;

  typedef struct packed {
    logic [VOLT_WIDTH-1:0] bus;
    logic [REMW-1:0]       rem_a;
    logic [REMW-1:0]       rem_b;
    logic [NW-1:0]         low_a;
    logic [NW-1:0]         low_b;
    logic [NW-1:0]         q_a;
    logic [NW-1:0]         q_b;
    logic                  neg_a;
    logic                  neg_b;
    logic                  ovf_a;
    logic                  ovf_b;
    logic                  zero;
  } div_stage_t;

  typedef struct packed {
    sector_e              sector;
    logic signed [NW-1:0] a;
    logic signed [XW-1:0] kb;
    logic signed [XW-1:0] tb;
    logic                 zero;
  } sect_t;

  typedef struct packed {
    sector_e              sector;
    logic signed [TW-1:0] t1;
    logic signed [TW-1:0] t2;
    logic signed [CW-1:0] c;
    logic                 zero;
  } time_t;

endpackage

[hw/rtl/svpd_div.sv]
// ----------------------------------------------------------------------------
// svpd_div
// Pipelined restoring divider: alpha and beta magnitudes over the bus
// voltage, one quotient bit per stage.
// ----------------------------------------------------------------------------
module svpd_div import svpd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [VOLT_WIDTH-1:0] alpha_i,
  input  logic [VOLT_WIDTH-1:0] beta_i,
  input  logic [VOLT_WIDTH-1:0] bus_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output div_stage_t            out_o
);

  localparam int NS = NW + 1;

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;
  div_stage_t    st_q [NS];
  div_stage_t    st_d [NS];
  logic [REMW-1:0] mag_a, mag_b;
  logic [REMW:0]   bus4;

  function automatic logic [REMW-1:0] magnitude(input logic [VOLT_WIDTH-1:0] v);
    logic [REMW-1:0] e;
    e = {v[VOLT_WIDTH-1], v};
    return v[VOLT_WIDTH-1] ? (~e + REMW'(1)) : e;
  endfunction

  function automatic div_stage_t step(input div_stage_t s);
    div_stage_t     r;
    logic [REMW:0]  trial;
    logic           ge;
    r     = s;
    trial = {s.rem_a, s.low_a[NW-1]};
    ge    = trial >= {2'b00, s.bus};
    r.rem_a = ge ? REMW'(trial - {2'b00, s.bus}) : trial[REMW-1:0];
    r.q_a   = {s.q_a[NW-2:0], ge};
    r.low_a = {s.low_a[NW-2:0], 1'b0};
    trial = {s.rem_b, s.low_b[NW-1]};
    ge    = trial >= {2'b00, s.bus};
    r.rem_b = ge ? REMW'(trial - {2'b00, s.bus}) : trial[REMW-1:0];
    r.q_b   = {s.q_b[NW-2:0], ge};
    r.low_b = {s.low_b[NW-2:0], 1'b0};
    return r;
  endfunction

  assign mag_a = magnitude(alpha_i);
  assign mag_b = magnitude(beta_i);
  assign bus4  = {bus_i, 2'b00};

  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_comb begin
    st_d[0].bus   = bus_i;
    st_d[0].rem_a = mag_a >> 2;
    st_d[0].rem_b = mag_b >> 2;
    st_d[0].low_a = {mag_a[1:0], {FRAC_BITS{1'b0}}};
    st_d[0].low_b = {mag_b[1:0], {FRAC_BITS{1'b0}}};
    st_d[0].q_a   = '0;
    st_d[0].q_b   = '0;
    st_d[0].neg_a = alpha_i[VOLT_WIDTH-1];
    st_d[0].neg_b = beta_i[VOLT_WIDTH-1];
    st_d[0].ovf_a = {1'b0, mag_a} >= bus4;
    st_d[0].ovf_b = {1'b0, mag_b} >= bus4;
    st_d[0].zero  = bus_i == '0;
    for (int k = 1; k < NS; k++) begin
      st_d[k] = step(st_q[k-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      if (en[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];
  assign out_o       = st_q[NS-1];

endmodule

[hw/rtl/svpd_sector.sv]
// ----------------------------------------------------------------------------
// svpd_sector
// Saturate the quotients to Q2.F, find the sector and form beta/sqrt3 terms.
// ----------------------------------------------------------------------------
module svpd_sector import svpd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  div_stage_t in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output sect_t      out_o
);

  logic                 v_q;
  logic                 en;
  sect_t                st_q, st_d;
  logic signed [NW-1:0] a, b;
  logic signed [PW-1:0] ka, kbx, tbx;

  function automatic logic signed [NW-1:0] saturate(input logic [NW-1:0] q,
                                                    input logic neg, input logic ovf);
    logic [NW-1:0] m;
    if (neg) begin
      m = (ovf || q > QLIM) ? QLIM : q;
      return $signed(~m + NW'(1));
    end
    return (ovf || q >= QLIM) ? $signed(QLIM - NW'(1)) : $signed(q);
  endfunction

  // shift right by F, rounding toward zero
  function automatic logic signed [XW-1:0] trunc_f(input logic signed [PW-1:0] x);
    logic signed [PW-1:0] bias;
    bias = x[PW-1] ? PW'({FRAC_BITS{1'b1}}) : '0;
    return XW'((x + bias) >>> FRAC_BITS);
  endfunction

  assign a   = saturate(in_i.q_a, in_i.neg_a, in_i.ovf_a);
  assign b   = saturate(in_i.q_b, in_i.neg_b, in_i.ovf_b);
  assign ka  = $signed({{(KW-FRAC_BITS){a[NW-1]}}, a, {FRAC_BITS{1'b0}}});
  assign kbx = $signed(K1) * b;
  assign tbx = $signed(K2) * b;

  always_comb begin
    st_d.a    = a;
    st_d.kb   = trunc_f(kbx);
    st_d.tb   = trunc_f(tbx);
    st_d.zero = in_i.zero;
    if (!b[NW-1]) begin
      if (!a[NW-1]) st_d.sector = (kbx > ka) ? SECT_2 : SECT_1;
      else          st_d.sector = (-kbx > ka) ? SECT_3 : SECT_2;
    end else begin
      if (!a[NW-1]) st_d.sector = (-kbx > ka) ? SECT_5 : SECT_6;
      else          st_d.sector = (kbx > ka) ? SECT_4 : SECT_5;
    end
  end

  assign en = !v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q <= st_d;
    end
  end

  assign in_ready_o  = en;
  assign out_valid_o = v_q;
  assign out_o       = st_q;

endmodule

[hw/rtl/svpd_time.sv]
// ----------------------------------------------------------------------------
// svpd_time
// Select the sector's time terms, scale them by the period and form the
// center count; two register stages.
// ----------------------------------------------------------------------------
module svpd_time import svpd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [PER_W-1:0] period_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sect_t            in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output time_t            out_o
);

  logic                  va_q, vb_q, en_a, en_b;
  sector_e               sec_a_q;
  logic                  zero_a_q;
  logic signed [PRW-1:0] p1_q, p2_q;
  logic signed [XW-1:0]  x1, x2, a_x;
  logic signed [PER_W:0] per_s;
  time_t                 st_q, st_d;
  logic signed [TW-1:0]  t1, t2;
  logic signed [CW-1:0]  sum;

  function automatic logic signed [TW-1:0] trunc_t(input logic signed [PRW-1:0] p);
    logic signed [PRW-1:0] bias;
    bias = p[PRW-1] ? PRW'({FRAC_BITS{1'b1}}) : '0;
    return TW'((p + bias) >>> FRAC_BITS);
  endfunction

  assign a_x   = XW'(in_i.a);
  assign per_s = $signed({1'b0, period_i});

  always_comb begin
    unique case (in_i.sector)
      SECT_1: begin x1 = a_x - in_i.kb;  x2 = in_i.tb;          end
      SECT_2: begin x1 = a_x + in_i.kb;  x2 = in_i.kb - a_x;    end
      SECT_3: begin x1 = in_i.tb;        x2 = -a_x - in_i.kb;   end
      SECT_4: begin x1 = in_i.kb - a_x;  x2 = -in_i.tb;         end
      SECT_5: begin x1 = -a_x - in_i.kb; x2 = a_x - in_i.kb;    end
      default: begin x1 = -in_i.tb;      x2 = a_x + in_i.kb;    end
    endcase
  end

  assign t1  = trunc_t(p1_q);
  assign t2  = trunc_t(p2_q);
  assign sum = CW'(per_s) + CW'(t1) + CW'(t2);

  always_comb begin
    st_d.sector = sec_a_q;
    st_d.zero   = zero_a_q;
    st_d.t1     = t1;
    st_d.t2     = t2;
    st_d.c      = (sum + $signed(CW'(sum[CW-1]))) >>> 1;
  end

  assign en_b = !vb_q || out_ready_i;
  assign en_a = !va_q || en_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (en_a) va_q <= in_valid_i;
      if (en_b) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      sec_a_q  <= in_i.sector;
      zero_a_q <= in_i.zero;
      p1_q     <= x1 * per_s;
      p2_q     <= x2 * per_s;
    end
    if (en_b) begin
      st_q <= st_d;
    end
  end

  assign in_ready_o  = en_a;
  assign out_valid_o = vb_q;
  assign out_o       = st_q;

endmodule

[hw/rtl/svpd_duty.sv]
// ----------------------------------------------------------------------------
// svpd_duty
// Derive the three phase counts from the center count (half period on a
// zero bus), clamp them and hold the result in the output register.
// ----------------------------------------------------------------------------
module svpd_duty import svpd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [PER_W-1:0] period_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  time_t            in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [PER_W-1:0] duty_u_o,
  output logic [PER_W-1:0] duty_v_o,
  output logic [PER_W-1:0] duty_w_o,
  output logic [2:0]       sector_o,
  output logic             limited_o
);

  logic                 v_q, en;
  logic signed [DW-1:0] c, t1, t2, du, dv, dw;
  logic [PER_W-1:0]     cu, cv, cw;
  logic                 lu, lv, lw;
  logic [PER_W-1:0]     du_q, dv_q, dw_q;
  logic [2:0]           sec_q;
  logic                 lim_q;

  function automatic logic [PER_W:0] clamp(input logic signed [DW-1:0] d,
                                           input logic [PER_W-1:0] p);
    if (d[DW-1]) return {1'b1, {PER_W{1'b0}}};
    if (d > $signed(DW'(p))) return {1'b1, p};
    return {1'b0, d[PER_W-1:0]};
  endfunction

  assign c  = DW'(in_i.c);
  assign t1 = DW'(in_i.t1);
  assign t2 = DW'(in_i.t2);

  always_comb begin
    unique case (in_i.sector)
      SECT_1: begin du = c; dv = du - t1; dw = dv - t2; end
      SECT_2: begin dv = c; du = dv - t2; dw = du - t1; end
      SECT_3: begin dv = c; dw = dv - t1; du = dw - t2; end
      SECT_4: begin dw = c; dv = dw - t2; du = dv - t1; end
      SECT_5: begin dw = c; du = dw - t1; dv = du - t2; end
      default: begin du = c; dw = du - t2; dv = dw - t1; end
    endcase
  end

  assign {lu, cu} = clamp(du, period_i);
  assign {lv, cv} = clamp(dv, period_i);
  assign {lw, cw} = clamp(dw, period_i);

  assign en = !v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (in_i.zero) begin
        du_q  <= period_i >> 1;
        dv_q  <= period_i >> 1;
        dw_q  <= period_i >> 1;
        sec_q <= SECT_1;
        lim_q <= 1'b1;
      end else begin
        du_q  <= cu;
        dv_q  <= cv;
        dw_q  <= cw;
        sec_q <= in_i.sector;
        lim_q <= lu || lv || lw;
      end
    end
  end

  assign in_ready_o  = en;
  assign out_valid_o = v_q;
  assign duty_u_o    = du_q;
  assign duty_v_o    = dv_q;
  assign duty_w_o    = dw_q;
  assign sector_o    = sec_q;
  assign limited_o   = lim_q;

endmodule

[hw/rtl/space_vector_pwm_duty_top.sv]
// Pipeline: 19 divider stages, 1 sector stage, 2 time stages and 1 output
//   register lie between input transfer and result.
// Throughput: one vector per cycle unless stalled; the divider, one quotient
//   bit per stage, sets the depth, each stage holds or advances on its own.
// Reset: asynchronous active low; clears all valid bits, period to 1000.
// ----------------------------------------------------------------------------
// space_vector_pwm_duty_top
// Six-sector space vector PWM: normalizes an alpha/beta vector by the bus
// voltage and produces three centered compare counts per vector.
// ----------------------------------------------------------------------------
module space_vector_pwm_duty_top import svpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // period register write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  // input vectors
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // volt_alpha, volt_beta, bus_volt
  // duty results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // duty_u, duty_v, duty_w, sector_num,
                                      // limited, zero pad
);

  logic [PER_W-1:0] period_q;

  logic       div_valid, div_ready, sec_valid, sec_ready, tim_valid, tim_ready;
  div_stage_t div_out;
  sect_t      sec_out;
  time_t      tim_out;

  logic [PER_W-1:0] duty_u, duty_v, duty_w;
  logic [2:0]       sector;
  logic             limited;

  // The register takes every write; software must write it only while idle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RST;
    end else if (cfg_valid_i) begin
      period_q <= cfg_data_i;
    end
  end

  // Divide alpha and beta by the bus voltage, one quotient bit per stage.
  svpd_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .alpha_i     (s_axis_tdata[15:0]),
    .beta_i      (s_axis_tdata[31:16]),
    .bus_i       (s_axis_tdata[47:32]),
    .out_valid_o (div_valid),
    .out_ready_i (div_ready),
    .out_o       (div_out)
  );

  // Saturate, find the sector, form the beta/sqrt3 terms.
  svpd_sector u_sector (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div_valid),
    .in_ready_o  (div_ready),
    .in_i        (div_out),
    .out_valid_o (sec_valid),
    .out_ready_i (sec_ready),
    .out_o       (sec_out)
  );

  // Scale the two active times by the period, then the center count.
  svpd_time u_time (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .period_i    (period_q),
    .in_valid_i  (sec_valid),
    .in_ready_o  (sec_ready),
    .in_i        (sec_out),
    .out_valid_o (tim_valid),
    .out_ready_i (tim_ready),
    .out_o       (tim_out)
  );

  // Phase counts, clamp to 0..period, output register.
  svpd_duty u_duty (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .period_i    (period_q),
    .in_valid_i  (tim_valid),
    .in_ready_o  (tim_ready),
    .in_i        (tim_out),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .duty_u_o    (duty_u),
    .duty_v_o    (duty_v),
    .duty_w_o    (duty_w),
    .sector_o    (sector),
    .limited_o   (limited)
  );

  assign m_axis_tdata = {4'b0000, limited, sector, duty_w, duty_v, duty_u};

  // Every result carries a sector from one to six.
  a_sector_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (sector >= 3'd1 && sector <= 3'd6))
    else $error("sector out of range");

  // Sector one without clamping orders the phases U >= V >= W.
  a_sector1_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && sector == SECT_1 && !limited) |->
      (duty_u >= duty_v && duty_v >= duty_w))
    else $error("sector 1 phase order broken");

  // Sector four without clamping orders the phases W >= V >= U.
  a_sector4_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && sector == SECT_4 && !limited) |->
      (duty_w >= duty_v && duty_v >= duty_u))
    else $error("sector 4 phase order broken");

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives alpha/beta/bus vectors and period writes into the space vector PWM
// duty pipeline, predicts every duty result in fixed point and compares each
// output transfer field by field under varying idle and stall pressure.
// ----------------------------------------------------------------------------
module testbench;
  import svpd_pkg::*;

  typedef struct {
    logic [15:0] du;
    logic [15:0] dv;
    logic [15:0] dw;
    logic [2:0]  sect;
    logic        lim;
  } duty_t;

  localparam longint KInv    = (InvSqrt3Q24 + QHalf) >>> QShift;
  localparam longint KTwoInv = (TwoInvSqrt3Q24 + QHalf) >>> QShift;
  localparam int     WatchLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;

  longint      period_q = 1000;
  duty_t       duty_expect_q[$];
  int          errors = 0;
  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;
  int          quiet_cycles = 0;

  space_vector_pwm_duty_top dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint trunc_shr(longint x, int sh);
    if (x < 0) return -((-x) >>> sh);
    return x >>> sh;
  endfunction

  function automatic longint norm_q(longint v, longint bus);
    longint q;
    q = (v * (64'sd1 << FRAC_BITS)) / bus;
    if (q > (64'sd1 << (FRAC_BITS + 1)) - 1) q = (64'sd1 << (FRAC_BITS + 1)) - 1;
    if (q < -(64'sd1 << (FRAC_BITS + 1))) q = -(64'sd1 << (FRAC_BITS + 1));
    return q;
  endfunction

  function automatic longint on_time(longint x);
    return trunc_shr(x * period_q, FRAC_BITS);
  endfunction

  function automatic logic [15:0] clamp_count(longint d, inout logic lim);
    if (d < 0) begin
      lim = 1'b1;
      return 16'd0;
    end
    if (d > period_q) begin
      lim = 1'b1;
      return 16'(period_q);
    end
    return 16'(d);
  endfunction

  function automatic duty_t predict_duty(logic [15:0] al, logic [15:0] be, logic [15:0] bus);
    duty_t r;
    longint a, b, ka, kbx, kb, tb, t1, t2, c, du, dv, dw;
    logic lim;
    sector_e s;
    lim = 1'b0;
    if (bus == 0) begin
      r.du = 16'(period_q >> 1);
      r.dv = r.du;
      r.dw = r.du;
      r.sect = SECT_1;
      r.lim = 1'b1;
      return r;
    end
    a = norm_q(longint'($signed(al)), longint'(bus));
    b = norm_q(longint'($signed(be)), longint'(bus));
    ka = a * (64'sd1 << FRAC_BITS);
    kbx = KInv * b;
    if (b >= 0) begin
      if (a >= 0) s = (kbx > ka) ? SECT_2 : SECT_1;
      else s = (-kbx > ka) ? SECT_3 : SECT_2;
    end else begin
      if (a >= 0) s = (-kbx > ka) ? SECT_5 : SECT_6;
      else s = (kbx > ka) ? SECT_4 : SECT_5;
    end
    kb = trunc_shr(KInv * b, FRAC_BITS);
    tb = trunc_shr(KTwoInv * b, FRAC_BITS);
    case (s)
      SECT_1: begin
        t1 = on_time(a - kb); t2 = on_time(tb);
        c = trunc_shr(period_q + t1 + t2, 1);
        du = c; dv = du - t1; dw = dv - t2;
      end
      SECT_2: begin
        t1 = on_time(a + kb); t2 = on_time(kb - a);
        c = trunc_shr(period_q + t1 + t2, 1);
        dv = c; du = dv - t2; dw = du - t1;
      end
      SECT_3: begin
        t1 = on_time(tb); t2 = on_time(-a - kb);
        c = trunc_shr(period_q + t1 + t2, 1);
        dv = c; dw = dv - t1; du = dw - t2;
      end
      SECT_4: begin
        t1 = on_time(kb - a); t2 = on_time(-tb);
        c = trunc_shr(period_q + t1 + t2, 1);
        dw = c; dv = dw - t2; du = dv - t1;
      end
      SECT_5: begin
        t1 = on_time(-a - kb); t2 = on_time(a - kb);
        c = trunc_shr(period_q + t1 + t2, 1);
        dw = c; du = dw - t1; dv = du - t2;
      end
      default: begin
        t1 = on_time(-tb); t2 = on_time(a + kb);
        c = trunc_shr(period_q + t1 + t2, 1);
        du = c; dw = du - t2; dv = dw - t1;
      end
    endcase
    r.du = clamp_count(du, lim);
    r.dv = clamp_count(dv, lim);
    r.dw = clamp_count(dw, lim);
    r.sect = s;
    r.lim = lim;
    return r;
  endfunction

  // Count cycles with no transfer on any channel; give up at the limit.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
        $display("%0t watchdog: no transfer for %0d cycles", $time, WatchLimit);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Check each output transfer against the oldest predicted duty set.
  always @(posedge clk_i) begin
    duty_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (duty_expect_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, m_axis_tdata);
        errors++;
      end else begin
        e = duty_expect_q.pop_front();
        if (m_axis_tdata[15:0] !== e.du || m_axis_tdata[31:16] !== e.dv ||
            m_axis_tdata[47:32] !== e.dw || m_axis_tdata[50:48] !== e.sect ||
            m_axis_tdata[51] !== e.lim) begin
          $display("%0t mismatch exp u=%0d v=%0d w=%0d s=%0d l=%0b act u=%0d v=%0d w=%0d s=%0d l=%0b",
                   $time, e.du, e.dv, e.dw, e.sect, e.lim,
                   m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
                   m_axis_tdata[50:48], m_axis_tdata[51]);
          errors++;
        end
      end
    end
  end

  // Randomly stall the result side at the falling edge.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Drop valid only while idling, so back-to-back items keep it high.
  task automatic send_vector(logic [15:0] al, logic [15:0] be, logic [15:0] bus);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  <= {bus, be, al};
    s_axis_tvalid <= 1'b1;
    duty_expect_q.push_back(predict_duty(al, be, bus));
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (duty_expect_q.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_period(logic [15:0] p);
    drain();
    cfg_data_i  <= p;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    period_q = p;
  endtask

  // Pick a bus voltage: mostly 16000 and up, sometimes tiny, zero or any value.
  function automatic logic [15:0] pick_bus();
    case ($urandom_range(9))
      0: return 16'(0);
      1: return 16'($urandom_range(1, 16));
      2: return 16'($urandom);
      default: return 16'($urandom_range(16000, 65535));
    endcase
  endfunction

  task automatic test_directed;
    send_vector(16'h0000, 16'h0000, 16'd0);
    send_vector(16'h7fff, 16'h8000, 16'd0);
    send_vector(16'h0000, 16'h0000, 16'd30000);
    send_vector(16'h7fff, 16'h7fff, 16'd1);
    send_vector(16'h8000, 16'h8000, 16'd1);
    send_vector(16'h7fff, 16'h0000, 16'hffff);
    send_vector(16'h8000, 16'h0000, 16'hffff);
    send_vector(16'h0000, 16'h7fff, 16'hffff);
    send_vector(16'h0000, 16'h8000, 16'hffff);
    send_vector(16'd10000, 16'd3000, 16'd40000);
    send_vector(16'd3000, 16'd10000, 16'd40000);
    send_vector(-16'sd6000, 16'd9000, 16'd40000);
    send_vector(-16'sd10000, -16'sd3000, 16'd40000);
    send_vector(16'd2000, -16'sd12000, 16'd40000);
    send_vector(16'd12000, -16'sd4000, 16'd40000);
    send_vector(-16'sd2000, -16'sd12000, 16'd40000);
    send_vector(16'd30000, 16'd20000, 16'd20000);
    send_vector(-16'sd32768, 16'd1, 16'd2);
  endtask

  task automatic test_random(int n, int idle, int stall);
    src_idle_pct = idle;
    sink_stall_pct = stall;
    repeat (n) send_vector(16'($urandom), 16'($urandom), pick_bus());
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    write_period(16'd1);
    test_directed();
    write_period(16'hffff);
    test_directed();
    write_period(16'd0);
    test_random(40, 0, 0);
    write_period(16'd1000);
    test_random(200, 0, 0);
    // hold off until the pipeline has emptied once
    drain();
    write_period(16'($urandom_range(1, 65535)));
    test_random(200, 65, 0);
    write_period(16'($urandom_range(1, 200)));
    test_random(200, 0, 65);
    write_period(16'hffff);
    test_random(200, 9, 9);
    write_period(16'd3);
    test_random(60, 9, 9);
    drain();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[space_vector_pwm_duty_top.f]
hw/rtl/svpd_pkg.sv
hw/rtl/svpd_div.sv
hw/rtl/svpd_sector.sv
hw/rtl/svpd_time.sv
hw/rtl/svpd_duty.sv
hw/rtl/space_vector_pwm_duty_top.sv
test/testbench.sv
